// ===== rtl/brfifo_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brfifo_pkg
// Shared types, codes and sizes of the byte ring FIFO with frame commit.
// ----------------------------------------------------------------------------
package brfifo_pkg;

  // Largest ring in bytes; must be a power of two
  localparam int MAX_DEPTH = 4096;
  localparam int PTR_W     = $clog2(MAX_DEPTH);

  // Widths fixed by the item formats
  localparam int CFG_DATA_W = 16;
  localparam int CNT_W      = 12;

  // Register indexes
  localparam logic REG_REQ_SIZE = 1'b0;
  localparam logic REG_ATOMIC   = 1'b1;

  // Request codes
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // Frame status codes
  localparam logic [1:0] ST_OPEN     = 2'd0;
  localparam logic [1:0] ST_COMMIT   = 2'd1;
  localparam logic [1:0] ST_ROLLBACK = 2'd2;
  localparam logic [1:0] ST_TRUNC    = 2'd3;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic             read_valid;
    logic [7:0]       read_byte;
    logic             byte_stored;
    logic [1:0]       frame_status;
    logic [CNT_W-1:0] fill_count;
    logic [CNT_W-1:0] free_space;
  } out_item_t;

  // Configuration seen by the pointer logic
  typedef struct packed {
    logic [PTR_W-1:0] mask;
    logic             atomic;
    logic             clear;
  } cfg_state_t;

  // Result of one beat, minus the byte read from the store
  typedef struct packed {
    logic             valid;
    logic             read_valid;
    logic             byte_stored;
    logic [1:0]       frame_status;
    logic [CNT_W-1:0] fill_count;
    logic [CNT_W-1:0] free_space;
  } ctrl_res_t;

endpackage
`default_nettype wire

// ===== rtl/brfifo_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brfifo_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brfifo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/brfifo_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brfifo_cfg
// Configuration registers; turns the requested size into a ring index mask.
// ----------------------------------------------------------------------------
module brfifo_cfg
  import brfifo_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output      cfg_state_t            cfg_st
);

  logic [PTR_W-1:0] mask_r, mask_nxt;
  logic             atomic_r, atomic_nxt;
  logic             clear;
  logic             size_big;
  logic [PTR_W-1:0] req_m1;
  logic [PTR_W-1:0] smear;

  // Clamp the request, then round up to a power of two of at least 2
  always_comb begin
    size_big = (cfg_wdata == '0) ||
               (cfg_wdata >= CFG_DATA_W'(MAX_DEPTH));
    req_m1   = size_big ? {PTR_W{1'b1}} : (cfg_wdata[PTR_W-1:0] - PTR_W'(1));
    for (int i = 0; i < PTR_W; i++) begin
      smear[i] = |(req_m1 >> i);
    end
  end

  // Decode register writes
  always_comb begin
    mask_nxt   = mask_r;
    atomic_nxt = atomic_r;
    clear      = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_REQ_SIZE: begin
          mask_nxt = smear | PTR_W'(1);
          clear    = 1'b1;
        end
        REG_ATOMIC: begin
          atomic_nxt = cfg_wdata[0];
        end
        default: begin
          mask_nxt = mask_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= {PTR_W{1'b1}};
      atomic_r <= 1'b1;
    end else begin
      mask_r   <= mask_nxt;
      atomic_r <= atomic_nxt;
    end
  end

  assign cfg_st.mask   = mask_r;
  assign cfg_st.atomic = atomic_r;
  assign cfg_st.clear  = clear;

endmodule
`default_nettype wire

// ===== rtl/brfifo_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brfifo_ctrl
// Ring pointers, frame commit and rollback, and the per-beat result flags.
// ----------------------------------------------------------------------------
module brfifo_ctrl
  import brfifo_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire in_item_t         in_item,
  input  wire cfg_state_t       cfg_st,
  output      logic             ram_we,
  output      logic [PTR_W-1:0] ram_waddr,
  output      logic [7:0]       ram_wdata,
  output      logic             ram_re,
  output      logic [PTR_W-1:0] ram_raddr,
  output      ctrl_res_t        res
);

  logic [PTR_W-1:0] ch_r, ch_nxt;
  logic [PTR_W-1:0] wh_r, wh_nxt;
  logic [PTR_W-1:0] rt_r, rt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             valid_r;
  logic             rvalid_r, rvalid_nxt;
  logic             stored_r, stored_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             ovf_now;
  logic [PTR_W-1:0] used;
  logic [PTR_W-1:0] room;
  logic [PTR_W-1:0] committed;
  logic [PTR_W-1:0] fill;
  logic [PTR_W-1:0] used_out;

  // Work out one beat against the current pointers
  always_comb begin
    ch_nxt     = ch_r;
    wh_nxt     = wh_r;
    rt_nxt     = rt_r;
    ovf_nxt    = ovf_r;
    ovf_now    = ovf_r;
    rvalid_nxt = 1'b0;
    stored_nxt = 1'b0;
    status_nxt = ST_OPEN;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    used       = (wh_r - rt_r) & cfg_st.mask;
    room       = cfg_st.mask - used;
    committed  = (ch_r - rt_r) & cfg_st.mask;
    if (start) begin
      case (in_item.req_type)
        REQ_POP: begin
          if (committed != '0) begin
            ram_re     = 1'b1;
            rvalid_nxt = 1'b1;
            rt_nxt     = (rt_r + PTR_W'(1)) & cfg_st.mask;
          end
        end
        default: begin
          // Store the byte unless the frame already overflowed or the ring is full
          if (!ovf_r && room != '0) begin
            ram_we     = 1'b1;
            wh_nxt     = (wh_r + PTR_W'(1)) & cfg_st.mask;
            stored_nxt = 1'b1;
          end else begin
            ovf_now = 1'b1;
          end
          // Close the frame: commit, roll back or truncate
          if (in_item.frame_last) begin
            if (ovf_now) begin
              if (cfg_st.atomic) begin
                wh_nxt     = ch_r;
                status_nxt = ST_ROLLBACK;
              end else begin
                ch_nxt     = wh_nxt;
                status_nxt = ST_TRUNC;
              end
            end else begin
              ch_nxt     = wh_nxt;
              status_nxt = ST_COMMIT;
            end
            ovf_nxt = 1'b0;
          end else begin
            ovf_nxt = ovf_now;
          end
        end
      endcase
    end
  end

  assign ram_waddr = wh_r;
  assign ram_wdata = in_item.data_byte;
  assign ram_raddr = rt_r;

  // Pointer state; a size write empties the ring
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_st.clear) begin
      ch_r  <= '0;
      wh_r  <= '0;
      rt_r  <= '0;
      ovf_r <= 1'b0;
    end else begin
      ch_r  <= ch_nxt;
      wh_r  <= wh_nxt;
      rt_r  <= rt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  // Result flags, shown for one cycle after the beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      rvalid_r <= 1'b0;
      stored_r <= 1'b0;
      status_r <= ST_OPEN;
    end else begin
      valid_r  <= start;
      rvalid_r <= rvalid_nxt;
      stored_r <= stored_nxt;
      status_r <= status_nxt;
    end
  end

  // Levels after the beat come straight from the updated pointers
  assign fill     = (ch_r - rt_r) & cfg_st.mask;
  assign used_out = (wh_r - rt_r) & cfg_st.mask;

  assign res.valid        = valid_r;
  assign res.read_valid   = rvalid_r;
  assign res.byte_stored  = stored_r;
  assign res.frame_status = status_r;
  assign res.fill_count   = CNT_W'(fill);
  assign res.free_space   = CNT_W'(cfg_st.mask - used_out);

  // A rolled-back frame leaves the write head on the commit point
  a_rollback_head: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && status_r == ST_ROLLBACK) |-> (wh_r == ch_r))
    else $error("write head not restored after rollback");

  // Committed bytes never exceed written bytes
  a_fill_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= used_out)
    else $error("commit point beyond write head");

  // Every accepted beat yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> valid_r)
    else $error("result missing after accepted beat");

  // A beat is either a read or a store, never both
  a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    rvalid_r |-> (!stored_r && status_r == ST_OPEN))
    else $error("pop result carries push flags");

endmodule
`default_nettype wire

// ===== rtl/byte_ring_fifo_frame_commit_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_fifo_frame_commit_top
// Byte ring FIFO with frame commit, atomic rollback or truncation.
// ----------------------------------------------------------------------------
// One beat is taken in every cycle: busy stays low, so a beat is accepted
// whenever start is high. Its result appears on out_item with out_valid high
// in the next cycle and must be taken in that cycle, since the receiver
// cannot stall. The byte store is a single RAM with one write and one
// registered read port; a pop reads it in the accept cycle. There is no
// clearing pass after reset. Writing the size register empties the ring
// and picks the capacity: zero or anything at or above the maximum gives
// the maximum, otherwise the request rounded up to a power of two of at
// least 2; one entry always stays free. Write configuration only while no
// result is pending.
// ----------------------------------------------------------------------------
module byte_ring_fifo_frame_commit_top
  import brfifo_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output      logic                  busy,
  input  wire in_item_t              in_item,
  output      logic                  out_valid,
  output      out_item_t             out_item,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_state_t       cfg_st;
  ctrl_res_t        res;
  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [PTR_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  brfifo_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_st    (cfg_st)
  );

  brfifo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .cfg_st    (cfg_st),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .res       (res)
  );

  brfifo_ram #(
    .WIDTH (8),
    .DEPTH (MAX_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy = 1'b0;

  // Assemble the result beat; the byte reads as zero when nothing was popped
  assign out_valid             = res.valid;
  assign out_item.read_valid   = res.read_valid;
  assign out_item.read_byte    = res.read_valid ? ram_rdata : 8'd0;
  assign out_item.byte_stored  = res.byte_stored;
  assign out_item.frame_status = res.frame_status;
  assign out_item.fill_count   = res.fill_count;
  assign out_item.free_space   = res.free_space;

endmodule
`default_nettype wire
